// ===== src/mud_pkg.sv =====
// ----------------------------------------------------------------------------
// Multipart upload deframer package
// Shared constants, types and helpers for the deframer and its submodules.
// ----------------------------------------------------------------------------
package mud_pkg;

	// Boundary and holdback sizing.
	localparam int MAX_BOUNDARY     = 48;
	localparam int HOLD_EXTRA       = 8;
	localparam int MARKER_EXTRA     = 4;
	localparam int HOLD_DEPTH       = MAX_BOUNDARY + HOLD_EXTRA;
	localparam int MARKER_LEN       = MAX_BOUNDARY + MARKER_EXTRA;
	localparam int FILL_W           = $clog2(HOLD_DEPTH + 1);
	localparam int BLEN_W           = 6;
	localparam int CHAR_REGS        = 6;
	localparam int TAIL_POS_MAX     = 4;
	localparam int POS_W            = $clog2(TAIL_POS_MAX + 1);

	// Header skipping limit.
	localparam int PENDING_CAPACITY = 1536;
	localparam int HDR_CNT_W        = $clog2(PENDING_CAPACITY + 1);

	// Configuration port sizing.
	localparam int DATA_W           = 64;
	localparam int PADDR_W          = 6;
	localparam int REG_SEL_LSB      = 3;

	// Framing characters.
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_DASH = 8'h2D;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_BYTE,
		ST_DONE,
		ST_OVERFLOW,
		ST_NOHDR,
		ST_NOTAIL
	} status_t;

	// Register map, one register per 8-byte slot.
	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_LENGTH,
		REG_CHARS_0,
		REG_CHARS_1,
		REG_CHARS_2,
		REG_CHARS_3,
		REG_CHARS_4,
		REG_CHARS_5
	} reg_idx_t;

	// Holdback line, entry 0 is the oldest byte.
	typedef logic [HOLD_DEPTH-1:0][7:0] hold_line_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic                          enable;
		logic [BLEN_W-1:0]             length;
		logic [MAX_BOUNDARY-1:0][7:0]  chars;
	} cfg_t;

	// Outcome of the tail marker search.
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} tail_t;

	// Boundary length clamped to the number of characters held.
	function automatic logic [BLEN_W-1:0] used_len(input logic [BLEN_W-1:0] len);
		return (len > BLEN_W'(MAX_BOUNDARY)) ? BLEN_W'(MAX_BOUNDARY) : len;
	endfunction

endpackage

// ===== src/mud_body_if.sv =====
// ----------------------------------------------------------------------------
// Body item channel
// Valid/ready channel carrying one body byte or an end-of-body mark.
// ----------------------------------------------------------------------------
interface mud_body_if;

	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] body_byte;

	modport source (output valid, output func, output body_byte, input ready);
	modport sink (input valid, input func, input body_byte, output ready);

endinterface

// ===== src/mud_result_if.sv =====
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying one released byte or a status report.
// ----------------------------------------------------------------------------
interface mud_result_if;

	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [2:0] status;
	logic       last_of_run;

	modport source (output valid, output payload_byte, output status, output last_of_run,
		input ready);
	modport sink (input valid, input payload_byte, input status, input last_of_run,
		output ready);

endinterface

// ===== src/multipart_upload_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Multipart upload deframer
// Strips multipart framing from a body byte stream and returns the payload.
// ----------------------------------------------------------------------------
// Usage:
//   The body channel takes one item per cycle when not stalled: a body byte
//   (func = 0) or an end-of-body mark (func = 1). The result channel gives
//   released payload bytes and status reports; last_of_run flags the final
//   result of an item. The APB port sets the framing mode and the boundary
//   string; write it only while no item is in flight.
//   An accepted item is registered in the input stage and its first result
//   then in the output register. Body bytes stream at one per cycle while
//   the receiver keeps up, as a byte leaves the stage when the next enters.
//   An end-of-body item emits up to four held bytes and a status (none after
//   overflow), one result per cycle when not stalled, and holds the stage meanwhile.
//   Reset returns the registers to their defaults and the block to header
//   skipping with an empty holdback line; no clearing pass is needed.
//   When the receiver stalls, the output register holds its result and the
//   input stage keeps one more item; body ready then drops until the
//   output register frees.
// ----------------------------------------------------------------------------
module multipart_upload_deframer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mud_pkg::PADDR_W-1:0] paddr,
	input  logic [mud_pkg::DATA_W-1:0]  pwdata,
	output logic [mud_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	mud_body_if.sink                    body,
	mud_result_if.source                result
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_FAILED
	} phase_t;

	mud_pkg::cfg_t                     cfg;
	mud_pkg::tail_t                    tail;

	// Input stage.
	logic                              valid_s1;
	logic                              func_s1;
	logic [7:0]                        byte_s1;

	// Deframing state.
	phase_t                            phase_q;
	phase_t                            phase_d;
	logic [1:0]                        crlf_q;
	logic [1:0]                        crlf_d;
	logic [mud_pkg::HDR_CNT_W-1:0]     hdr_cnt_q;
	logic [mud_pkg::HDR_CNT_W-1:0]     hdr_cnt_d;
	logic [mud_pkg::FILL_W-1:0]        fill_q;
	logic [mud_pkg::FILL_W-1:0]        fill_d;
	mud_pkg::hold_line_t               hb_q;
	logic [mud_pkg::POS_W-1:0]         sub_q;

	// Output register.
	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	mud_pkg::status_t                  out_status_q;
	logic                              out_last_q;

	// Stage control.
	logic                              res_valid;
	logic [7:0]                        res_byte;
	mud_pkg::status_t                  res_status;
	logic                              res_last;
	logic                              commit;
	logic                              rearm;
	logic                              hb_step;
	logic                              go;
	logic                              out_free;
	logic [mud_pkg::FILL_W-1:0]        keep;
	logic                              release_en;
	logic                              append;
	logic [mud_pkg::FILL_W-1:0]        wr_idx;
	logic [7:0]                        hb_head;

	mud_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mud_tail_search u_tail (
		.line (hb_q),
		.fill (fill_q),
		.cfg  (cfg),
		.tail (tail)
	);

	// Holdback release point and write position.
	assign keep = mud_pkg::FILL_W'(mud_pkg::used_len(cfg.length))
		+ mud_pkg::FILL_W'(mud_pkg::HOLD_EXTRA);
	assign release_en = (fill_q >= keep);
	assign append = release_en || (fill_q < mud_pkg::FILL_W'(mud_pkg::HOLD_DEPTH));
	assign wr_idx = release_en ? (fill_q - mud_pkg::FILL_W'(1)) : fill_q;

	// Oldest held bytes, as released one by one at end of body.
	always_comb begin
		case (sub_q[1:0])
			2'd0:    hb_head = hb_q[0];
			2'd1:    hb_head = hb_q[1];
			2'd2:    hb_head = hb_q[2];
			default: hb_head = hb_q[3];
		endcase
	end

	// Per-item work: the result of this cycle and the next state.
	always_comb begin
		res_valid  = 1'b0;
		res_byte   = '0;
		res_status = mud_pkg::ST_BYTE;
		res_last   = 1'b1;
		commit     = 1'b1;
		rearm      = 1'b0;
		hb_step    = 1'b0;
		phase_d    = phase_q;
		crlf_d     = crlf_q;
		hdr_cnt_d  = hdr_cnt_q;
		fill_d     = fill_q;

		if (!cfg.enable) begin
			// Pass-through: every item gives exactly one result.
			res_valid = 1'b1;
			if (func_s1) begin
				res_status = mud_pkg::ST_DONE;
			end else begin
				res_byte = byte_s1;
			end
		end else if (func_s1) begin
			// End of body: report (except after an overflow) and re-arm for the next body.
			unique case (phase_q)
				PH_HEADER: begin
					res_valid  = 1'b1;
					res_status = mud_pkg::ST_NOHDR;
					rearm      = 1'b1;
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					if (!tail.found) begin
						res_status = mud_pkg::ST_NOTAIL;
						rearm      = 1'b1;
					end else if (sub_q < tail.pos) begin
						res_byte = hb_head;
						res_last = 1'b0;
						commit   = 1'b0;
					end else begin
						res_status = mud_pkg::ST_DONE;
						rearm      = 1'b1;
					end
				end
				default: begin
					rearm = 1'b1;
				end
			endcase
		end else begin
			// Body byte.
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q >= mud_pkg::HDR_CNT_W'(mud_pkg::PENDING_CAPACITY)) begin
						res_valid  = 1'b1;
						res_status = mud_pkg::ST_OVERFLOW;
						phase_d    = PH_FAILED;
					end else begin
						hdr_cnt_d = hdr_cnt_q + mud_pkg::HDR_CNT_W'(1);
						case (crlf_q)
							2'd0: crlf_d = (byte_s1 == mud_pkg::CHAR_CR) ? 2'd1 : 2'd0;
							2'd1: crlf_d = (byte_s1 == mud_pkg::CHAR_LF) ? 2'd2 :
								(byte_s1 == mud_pkg::CHAR_CR) ? 2'd1 : 2'd0;
							2'd2: crlf_d = (byte_s1 == mud_pkg::CHAR_CR) ? 2'd3 : 2'd0;
							default: begin
								if (byte_s1 == mud_pkg::CHAR_LF) begin
									phase_d   = PH_PAYLOAD;
									crlf_d    = 2'd0;
									hdr_cnt_d = '0;
									fill_d    = '0;
								end else begin
									crlf_d = (byte_s1 == mud_pkg::CHAR_CR) ? 2'd1 : 2'd0;
								end
							end
						endcase
					end
				end
				PH_PAYLOAD: begin
					hb_step = 1'b1;
					if (release_en) begin
						res_valid = 1'b1;
						res_byte  = hb_head;
					end else if (append) begin
						fill_d = fill_q + mud_pkg::FILL_W'(1);
					end
				end
				default: begin
					// Failed phase drops body bytes.
				end
			endcase
		end

		if (rearm) begin
			phase_d   = PH_HEADER;
			crlf_d    = '0;
			hdr_cnt_d = '0;
			fill_d    = '0;
		end
	end

	// Stage handshake: the stage advances when its result has a place to go.
	assign out_free   = !out_valid_q || result.ready;
	assign go         = valid_s1 && (!res_valid || out_free);
	assign body.ready = !valid_s1 || (go && commit);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_HEADER;
			crlf_q      <= '0;
			hdr_cnt_q   <= '0;
			fill_q      <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (body.valid && body.ready) begin
				valid_s1 <= 1'b1;
			end else if (go && commit) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				if (commit) begin
					sub_q     <= '0;
					phase_q   <= phase_d;
					crlf_q    <= crlf_d;
					hdr_cnt_q <= hdr_cnt_d;
					fill_q    <= fill_d;
				end else begin
					sub_q <= sub_q + mud_pkg::POS_W'(1);
				end
			end
			if (go && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			func_s1 <= body.func;
			byte_s1 <= body.body_byte;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			out_byte_q   <= res_byte;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	// Holdback line: shift out the oldest byte on release, write the new
	// byte behind the newest held one.
	always_ff @(posedge clk) begin
		if (go && commit && hb_step) begin
			for (int i = 0; i < mud_pkg::HOLD_DEPTH - 1; i++) begin
				if (append && (wr_idx == mud_pkg::FILL_W'(i))) begin
					hb_q[i] <= byte_s1;
				end else if (release_en) begin
					hb_q[i] <= hb_q[i + 1];
				end
			end
			if (append && (wr_idx == mud_pkg::FILL_W'(mud_pkg::HOLD_DEPTH - 1))) begin
				hb_q[mud_pkg::HOLD_DEPTH - 1] <= byte_s1;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.payload_byte = out_byte_q;
	assign result.status       = out_status_q;
	assign result.last_of_run  = out_last_q;

endmodule

// ===== src/mud_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration registers
// APB-style register file holding the framing mode and the boundary string.
// ----------------------------------------------------------------------------
module mud_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mud_pkg::PADDR_W-1:0] paddr,
	input  logic [mud_pkg::DATA_W-1:0]  pwdata,
	output logic [mud_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output mud_pkg::cfg_t               cfg
);

	logic                                                  enable_q;
	logic [mud_pkg::BLEN_W-1:0]                            length_q;
	logic [mud_pkg::CHAR_REGS-1:0][mud_pkg::DATA_W-1:0]    chars_q;
	mud_pkg::reg_idx_t                                     sel;
	logic                                                  wr_en;

	// Register select from the 8-byte slot of the address.
	assign sel    = mud_pkg::reg_idx_t'(paddr[mud_pkg::PADDR_W-1:mud_pkg::REG_SEL_LSB]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			length_q <= mud_pkg::BLEN_W'(1);
			chars_q  <= '0;
		end else if (wr_en) begin
			unique case (sel)
				mud_pkg::REG_ENABLE:  enable_q   <= pwdata[0];
				mud_pkg::REG_LENGTH:  length_q   <= pwdata[mud_pkg::BLEN_W-1:0];
				mud_pkg::REG_CHARS_0: chars_q[0] <= pwdata;
				mud_pkg::REG_CHARS_1: chars_q[1] <= pwdata;
				mud_pkg::REG_CHARS_2: chars_q[2] <= pwdata;
				mud_pkg::REG_CHARS_3: chars_q[3] <= pwdata;
				mud_pkg::REG_CHARS_4: chars_q[4] <= pwdata;
				mud_pkg::REG_CHARS_5: chars_q[5] <= pwdata;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (sel)
			mud_pkg::REG_ENABLE:  prdata = mud_pkg::DATA_W'(enable_q);
			mud_pkg::REG_LENGTH:  prdata = mud_pkg::DATA_W'(length_q);
			mud_pkg::REG_CHARS_0: prdata = chars_q[0];
			mud_pkg::REG_CHARS_1: prdata = chars_q[1];
			mud_pkg::REG_CHARS_2: prdata = chars_q[2];
			mud_pkg::REG_CHARS_3: prdata = chars_q[3];
			mud_pkg::REG_CHARS_4: prdata = chars_q[4];
			mud_pkg::REG_CHARS_5: prdata = chars_q[5];
		endcase
	end

	// Character registers map onto the boundary string, low byte first.
	assign cfg.enable = enable_q;
	assign cfg.length = length_q;
	assign cfg.chars  = chars_q;

endmodule

// ===== src/mud_tail_search.sv =====
// ----------------------------------------------------------------------------
// Deframer tail search
// Finds the first CR LF dash dash boundary marker among the first few
// positions of the holdback line.
// ----------------------------------------------------------------------------
module mud_tail_search (
	input  mud_pkg::hold_line_t         line,
	input  logic [mud_pkg::FILL_W-1:0]  fill,
	input  mud_pkg::cfg_t               cfg,
	output mud_pkg::tail_t              tail
);

	localparam int SUM_W = mud_pkg::FILL_W + 1;

	logic [mud_pkg::FILL_W-1:0]                  tlen;
	logic [mud_pkg::MARKER_LEN-1:0][7:0]         marker;
	logic [mud_pkg::TAIL_POS_MAX:0]              hit;

	// Marker string: CR LF, two dashes, then the boundary characters.
	always_comb begin
		for (int j = 0; j < mud_pkg::MARKER_LEN; j++) begin
			if (j == 0) begin
				marker[j] = mud_pkg::CHAR_CR;
			end else if (j == 1) begin
				marker[j] = mud_pkg::CHAR_LF;
			end else if (j < mud_pkg::MARKER_EXTRA) begin
				marker[j] = mud_pkg::CHAR_DASH;
			end else begin
				marker[j] = cfg.chars[j - mud_pkg::MARKER_EXTRA];
			end
		end
	end

	// One comparator row per candidate start position. A position counts
	// only if the whole marker lies inside the filled part of the line.
	always_comb begin
		tlen = mud_pkg::FILL_W'(mud_pkg::used_len(cfg.length))
			+ mud_pkg::FILL_W'(mud_pkg::MARKER_EXTRA);
		for (int p = 0; p <= mud_pkg::TAIL_POS_MAX; p++) begin
			hit[p] = (SUM_W'(p) + SUM_W'(tlen)) <= SUM_W'(fill);
			for (int j = 0; j < mud_pkg::MARKER_LEN; j++) begin
				if ((mud_pkg::FILL_W'(j) < tlen) && (line[p + j] != marker[j])) begin
					hit[p] = 1'b0;
				end
			end
		end
	end

	// Lowest matching position wins.
	always_comb begin
		tail = '0;
		for (int p = mud_pkg::TAIL_POS_MAX; p >= 0; p--) begin
			if (hit[p]) begin
				tail.found = 1'b1;
				tail.pos   = mud_pkg::POS_W'(p);
			end
		end
	end

endmodule

// ===== tb/mud_payload_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer payload checker
// Snoops the register port and both item channels, keeps its own model of
// the header skipping and holdback line, and compares every result item
// against the oldest predicted one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module mud_payload_checker
	import mud_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	mud_body_if                body,
	mud_result_if              result,
	output int                 mismatches,
	output int                 outstanding
);

	typedef enum logic [1:0] {
		SKIP_HEADERS,
		IN_PAYLOAD,
		DISCARDING
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       last;
	} deframed_t;

	// Register copies, updated from snooped writes.
	logic              cfg_enable;
	logic [BLEN_W-1:0] cfg_length;
	logic [7:0]        cfg_chars [MAX_BOUNDARY];

	// Parser state.
	parse_phase_t parse_phase;
	logic [1:0]   crlf_seen;
	int unsigned  header_count;
	logic [7:0]   held_bytes [$];

	// Results predicted but not yet seen on the result channel.
	deframed_t deframed_results [$];

	function automatic int unsigned boundary_used();
		return (cfg_length > MAX_BOUNDARY) ? MAX_BOUNDARY : cfg_length;
	endfunction

	// Character j of the closing marker: CR LF, two dashes, then the boundary.
	function automatic logic [7:0] tail_char(input int unsigned j);
		if (j == 0) return CHAR_CR;
		if (j == 1) return CHAR_LF;
		if (j < MARKER_EXTRA) return CHAR_DASH;
		return cfg_chars[j - MARKER_EXTRA];
	endfunction

	function automatic void restart_body();
		parse_phase = SKIP_HEADERS;
		crlf_seen = 2'd0;
		header_count = 0;
		held_bytes.delete();
	endfunction

	// Works out the results of one accepted body item and queues them.
	function automatic void deframe_item(input logic is_end, input logic [7:0] b);
		deframed_t   run [$];
		deframed_t   closing;
		int unsigned keep;
		int unsigned span;
		int unsigned pos;
		bit          found;
		bit          hit;
		keep = boundary_used() + HOLD_EXTRA;
		span = boundary_used() + MARKER_EXTRA;
		found = 0;
		pos = 0;
		if (!cfg_enable) begin
			// Framing off: every item answers at once and the parser is untouched.
			if (is_end)
				run.push_back(deframed_t'{8'h00, ST_DONE, 1'b0});
			else
				run.push_back(deframed_t'{b, ST_BYTE, 1'b0});
		end else if (is_end) begin
			if (parse_phase == SKIP_HEADERS) begin
				run.push_back(deframed_t'{8'h00, ST_NOHDR, 1'b0});
			end else if (parse_phase == IN_PAYLOAD) begin
				// The first marker in the holdback decides; it may sit at most four in.
				for (int unsigned s = 0; !found && s + span <= held_bytes.size(); s++) begin
					hit = 1;
					for (int unsigned j = 0; j < span; j++)
						if (held_bytes[s + j] != tail_char(j)) hit = 0;
					if (hit) begin
						found = 1;
						pos = s;
					end
				end
				if (!found || pos > TAIL_POS_MAX) begin
					run.push_back(deframed_t'{8'h00, ST_NOTAIL, 1'b0});
				end else begin
					for (int unsigned j = 0; j < pos; j++)
						run.push_back(deframed_t'{held_bytes[j], ST_BYTE, 1'b0});
					run.push_back(deframed_t'{8'h00, ST_DONE, 1'b0});
				end
			end
			restart_body();
		end else if (parse_phase == SKIP_HEADERS) begin
			if (header_count + 1 > PENDING_CAPACITY) begin
				parse_phase = DISCARDING;
				run.push_back(deframed_t'{8'h00, ST_OVERFLOW, 1'b0});
			end else begin
				header_count++;
				case (crlf_seen)
				2'd0: crlf_seen = (b == CHAR_CR) ? 2'd1 : 2'd0;
				2'd1: crlf_seen = (b == CHAR_LF) ? 2'd2 : (b == CHAR_CR) ? 2'd1 : 2'd0;
				2'd2: crlf_seen = (b == CHAR_CR) ? 2'd3 : 2'd0;
				default: begin
					if (b == CHAR_LF) begin
						restart_body();
						parse_phase = IN_PAYLOAD;
					end else begin
						crlf_seen = (b == CHAR_CR) ? 2'd1 : 2'd0;
					end
				end
				endcase
			end
		end else if (parse_phase == IN_PAYLOAD) begin
			// A line holding keep bytes or more releases its oldest byte before taking the new one.
			if (held_bytes.size() >= keep)
				run.push_back(deframed_t'{held_bytes.pop_front(), ST_BYTE, 1'b0});
			if (held_bytes.size() < HOLD_DEPTH)
				held_bytes.push_back(b);
		end
		if (run.size() > 0) begin
			closing = run.pop_back();
			closing.last = 1'b1;
			run.push_back(closing);
		end
		foreach (run[i])
			deframed_results.push_back(run[i]);
	endfunction

	function automatic int check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s expected %0h actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Snoop writes and both channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		deframed_t want;
		reg_idx_t  idx;
		if (!arst_n) begin
			cfg_enable = 1'b0;
			cfg_length = BLEN_W'(1);
			foreach (cfg_chars[i])
				cfg_chars[i] = 8'h00;
			restart_body();
			deframed_results.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				idx = reg_idx_t'(paddr[PADDR_W-1:REG_SEL_LSB]);
				case (idx)
				REG_ENABLE: cfg_enable = pwdata[0];
				REG_LENGTH: cfg_length = pwdata[BLEN_W-1:0];
				default: begin
					for (int k = 0; k < 8; k++)
						cfg_chars[(int'(idx) - int'(REG_CHARS_0)) * 8 + k] = pwdata[8*k +: 8];
				end
				endcase
			end
			if (body.valid && body.ready)
				deframe_item(body.func, body.body_byte);
			if (result.valid && result.ready) begin
				if (deframed_results.size() == 0) begin
					$error("result item with nothing expected: payload_byte %0h status %0d",
						result.payload_byte, result.status);
					mismatches++;
				end else begin
					want = deframed_results.pop_front();
					mismatches += check_field("payload_byte", want.data, result.payload_byte);
					mismatches += check_field("status", want.status, result.status);
					mismatches += check_field("last_of_run", want.last, result.last_of_run);
				end
			end
		end
		outstanding = deframed_results.size();
	end

endmodule

// ===== tb/multipart_upload_deframer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multipart upload deframer testbench
// Drives body items and register writes into the deframer, with random
// gaps and stalls on both channels, while the payload checker predicts and
// compares every result item. Directed bodies come first, then the header
// limit, a holdback shrink and a long receiver hold-off, then random bodies.
// ----------------------------------------------------------------------------
module multipart_upload_deframer_top_tb;

	import mud_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 10;
	localparam int RANDOM_ITEMS    = 500;

	typedef enum int {
		NO_IDLE,
		SENDER_IDLE,
		RECEIVER_STALL,
		BOTH_IDLE
	} idle_mode_t;

	typedef enum int {
		WELL_FORMED,
		NO_HEADER_END,
		NO_TAIL,
		LONG_TRAILER,
		LENGTH_SWAP
	} body_shape_t;

	typedef enum int {
		CHARS_RANDOM,
		CHARS_ZERO,
		CHARS_ONES
	} char_style_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;

	idle_mode_t        idle_mode = NO_IDLE;
	int                stall_left = 0;
	int                cycle_count = 0;
	int                sent_items = 0;
	logic [7:0]        boundary [MAX_BOUNDARY];
	logic [BLEN_W-1:0] length_now;

	mud_body_if   body();
	mud_result_if result();

	multipart_upload_deframer_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.body    (body),
		.result  (result)
	);

	mud_payload_checker payload_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.body        (body),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multipart_upload_deframer_top_tb failed");
			$finish;
		end
	end

	// Receiver: a pending hold-off wins, else the idle mode decides.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else begin
				case (idle_mode)
				RECEIVER_STALL: result.ready <= ($urandom_range(99) >= 70);
				BOTH_IDLE:      result.ready <= ($urandom_range(99) >= 6);
				default:        result.ready <= 1'b1;
				endcase
			end
		end
	end

	function automatic bit sender_idles();
		case (idle_mode)
		SENDER_IDLE: return $urandom_range(99) < 70;
		BOTH_IDLE:   return $urandom_range(99) < 6;
		default:     return 1'b0;
		endcase
	endfunction

	// Byte biased toward the framing characters.
	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(7))
		0:       return CHAR_CR;
		1:       return CHAR_LF;
		2:       return CHAR_DASH;
		default: return 8'($urandom);
		endcase
	endfunction

	// Byte that can never start a header end.
	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		v = 8'($urandom);
		return (v == CHAR_CR) ? ~v : v;
	endfunction

	function automatic logic [BLEN_W-1:0] pick_length();
		case ($urandom_range(5))
		0:       return BLEN_W'(0);
		1:       return BLEN_W'(1);
		2:       return BLEN_W'(MAX_BOUNDARY);
		3:       return '1;
		default: return BLEN_W'($urandom_range(MAX_BOUNDARY - 1, 2));
		endcase
	endfunction

	function automatic body_shape_t pick_shape();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65) return WELL_FORMED;
		if (roll < 73) return NO_HEADER_END;
		if (roll < 81) return NO_TAIL;
		if (roll < 90) return LONG_TRAILER;
		return LENGTH_SWAP;
	endfunction

	// Offers one item from a falling edge and returns at the falling edge
	// after it was accepted.
	task automatic send_item(input logic is_end, input logic [7:0] b);
		while (sender_idles()) begin
			body.valid <= 1'b0;
			@(negedge clk);
		end
		body.valid <= 1'b1;
		body.func <= is_end;
		body.body_byte <= b;
		do @(posedge clk); while (!body.ready);
		@(negedge clk);
		sent_items++;
	endtask

	// Waits until every predicted result has come, then lets the block settle.
	task automatic drain();
		body.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << REG_SEL_LSB;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_length(input logic [BLEN_W-1:0] len);
		logic [DATA_W-1:0] value;
		value = {$urandom, $urandom};
		value[BLEN_W-1:0] = len;
		write_reg(REG_LENGTH, value);
		length_now = len;
	endtask

	// Writes every register; unused upper bits carry random data.
	task automatic configure(input logic en, input logic [BLEN_W-1:0] len,
		input char_style_t style);
		logic [DATA_W-1:0] value;
		foreach (boundary[i]) begin
			case (style)
			CHARS_ZERO: boundary[i] = 8'h00;
			CHARS_ONES: boundary[i] = 8'hFF;
			default:    boundary[i] = 8'($urandom);
			endcase
		end
		value = {$urandom, $urandom};
		value[0] = en;
		write_reg(REG_ENABLE, value);
		set_length(len);
		for (int r = 0; r < CHAR_REGS; r++) begin
			for (int k = 0; k < 8; k++)
				value[8*k +: 8] = boundary[8*r + k];
			write_reg(reg_idx_t'(int'(REG_CHARS_0) + r), value);
		end
	endtask

	task automatic send_header_end();
		send_item(1'b0, CHAR_CR);
		send_item(1'b0, CHAR_LF);
		send_item(1'b0, CHAR_CR);
		send_item(1'b0, CHAR_LF);
	endtask

	// CR LF, two dashes and the boundary at the current length.
	task automatic send_marker();
		int unsigned used;
		used = (length_now > MAX_BOUNDARY) ? MAX_BOUNDARY : length_now;
		send_item(1'b0, CHAR_CR);
		send_item(1'b0, CHAR_LF);
		send_item(1'b0, CHAR_DASH);
		send_item(1'b0, CHAR_DASH);
		for (int unsigned i = 0; i < used; i++)
			send_item(1'b0, boundary[i]);
	endtask

	// One body: headers, payload, closing marker and trailer, end mark, as the shape allows.
	task automatic send_body(input body_shape_t shape, input int data_len,
		input logic [BLEN_W-1:0] swap_len);
		int header_len;
		int trailer_len;
		header_len = $urandom_range(12);
		trailer_len = (shape == LONG_TRAILER) ? $urandom_range(10, 5) : $urandom_range(4);
		if (shape == NO_HEADER_END) begin
			repeat (header_len + 1) send_item(1'b0, plain_byte());
			send_item(1'b1, 8'($urandom));
			return;
		end
		repeat (header_len) send_item(1'b0, noisy_byte());
		send_header_end();
		repeat (data_len) send_item(1'b0, noisy_byte());
		if (shape == LENGTH_SWAP) begin
			// The boundary length changes with the holdback partly filled.
			drain();
			set_length(swap_len);
			repeat ($urandom_range(6)) send_item(1'b0, noisy_byte());
		end
		if (shape != NO_TAIL)
			send_marker();
		repeat (trailer_len) send_item(1'b0, noisy_byte());
		send_item(1'b1, 8'($urandom));
	endtask

	initial begin
		int phase_no;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		body.valid = 1'b0;
		body.func = 1'b0;
		body.body_byte = 8'h00;
		length_now = BLEN_W'(1);
		foreach (boundary[i])
			boundary[i] = 8'h00;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Framing off after reset: bytes and the end mark pass straight through.
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h5A);
		send_item(1'b1, 8'hFF);
		drain();

		// Zero boundary length: end before any header end, then a short body
		// whose header has a repeated CR and whose tail is just CR LF dashes.
		configure(1'b1, BLEN_W'(0), CHARS_ZERO);
		send_item(1'b1, 8'h00);
		send_item(1'b0, CHAR_CR);
		send_header_end();
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_marker();
		send_item(1'b1, 8'hA5);
		drain();

		// Header of exactly the capacity passes; one byte more overflows, and
		// the rest of that body is dropped until its end mark re-arms the parser.
		configure(1'b1, BLEN_W'(8), CHARS_RANDOM);
		repeat (PENDING_CAPACITY - 4) send_item(1'b0, plain_byte());
		send_header_end();
		repeat (3) send_item(1'b0, noisy_byte());
		send_marker();
		send_item(1'b1, 8'h00);
		repeat (PENDING_CAPACITY + 1) send_item(1'b0, plain_byte());
		repeat (5) send_item(1'b0, noisy_byte());
		send_item(1'b1, 8'h00);
		send_body(WELL_FORMED, 10, BLEN_W'(0));
		drain();

		// Length lowered with the holdback line filled to its release point.
		configure(1'b1, BLEN_W'(40), CHARS_RANDOM);
		send_body(LENGTH_SWAP, 60, BLEN_W'(2));
		drain();

		// Long receiver hold-off while a long body keeps coming.
		stall_left = HOLD_OFF_CYCLES;
		send_body(WELL_FORMED, 150, BLEN_W'(0));
		drain();

		// Random phases, one per idle mode, each with its share of the items
		// and fresh register settings between groups of bodies.
		sent_items = 0;
		phase_no = 0;
		while (phase_no < 4) begin
			idle_mode = idle_mode_t'(phase_no);
			while (sent_items < (phase_no + 1) * (RANDOM_ITEMS / 4)) begin
				drain();
				configure($urandom_range(4) != 0, pick_length(),
					char_style_t'(($urandom_range(5) < 4) ? 0 : $urandom_range(2, 1)));
				repeat ($urandom_range(3, 1)) begin
					send_body(pick_shape(),
						($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(24),
						BLEN_W'($urandom_range(63)));
					if ($urandom_range(5) == 0)
						drain();
				end
			end
			phase_no++;
		end

		// Let the last results out, then give the verdict.
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("multipart_upload_deframer_top_tb passed");
		end else begin
			$display("multipart_upload_deframer_top_tb failed");
		end
		$finish;
	end

endmodule
